FILE: rtl/fsjs_pkg.sv
// Package for the four-slot job scheduler: table sizes, field widths,
// policy and action codes, register indexes and the sequencer state type.
// No dependencies.
package fsjs_pkg;

  localparam int SLOTS    = 4;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int FILL_W   = $clog2(SLOTS + 1);
  localparam int UNITS_W  = 5;
  localparam int TAG_W    = 2;
  localparam int STAMP_W  = 32;
  localparam int QUANT_W  = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(3);

  // Scheduling policies.
  typedef enum logic [1:0] {
    MODE_FCFS = 2'd0,
    MODE_SJF  = 2'd1,
    MODE_PSJF = 2'd2,
    MODE_RR   = 2'd3
  } mode_t;

  // Item actions.
  localparam logic ACT_ADD      = 1'b0;
  localparam logic ACT_DISPATCH = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = CFG_IDX_W'(1);

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_UPDATE = 2'd2
  } state_t;

  // Slot index that follows idx, wrapping after the last slot.
  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W-1:0] res;
    if (idx == SLOT_W'(SLOTS - 1)) begin
      res = '0;
    end else begin
      res = idx + SLOT_W'(1);
    end
    return res;
  endfunction

endpackage

FILE: rtl/four_slot_job_scheduler.sv
// Four-slot job scheduler: job table, selection sequencer and update logic.
// Depends on fsjs_pkg.
//
// Usage
//   Command channel: a word (action, job_tag, burst_units) is taken at a
//   rising edge where start is high and busy is low. An add word with a
//   nonzero burst fills the slot under the fill pointer, if any is left; a
//   dispatch word makes one scheduling decision under scheduling_mode.
//   Result channel: exactly one result word per command, shown on accepted,
//   dispatched, slot_run, tag_run, units_run and job_done for one cycle
//   while done is high. The receiver cannot hold it off, and the block
//   never needs it to: the result register is written once per command.
//   Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
//   cfg_ready is always high; write only while no command is in flight.
// Sequencing
//   Add and FCFS dispatch words go from idle straight to the update state;
//   done rises as that state ends, and busy drops as done rises, so a new
//   word can be taken while done is high but not before. SJF, preemptive
//   SJF and round robin dispatch words first walk the table one slot per
//   cycle through the single shared compare unit, then go to the update state.
// Reset
//   rst (synchronous, active high) empties the table, clears the stamps,
//   the fill pointer, the job count and the walk pointer, and restores
//   FCFS with a round robin quantum of 3. No result is pending after reset.
module four_slot_job_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic [fsjs_pkg::TAG_W-1:0]      job_tag,
  input  logic [fsjs_pkg::UNITS_W-1:0]    burst_units,
  // result channel
  output logic                            done,
  output logic                            accepted,
  output logic                            dispatched,
  output logic [1:0]                      slot_run,
  output logic [fsjs_pkg::TAG_W-1:0]      tag_run,
  output logic [fsjs_pkg::UNITS_W-1:0]    units_run,
  output logic                            job_done,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fsjs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsjs_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  fsjs_pkg::mode_t                      scheduling_mode;
  logic [fsjs_pkg::QUANT_W-1:0]         rr_quantum;

  // Job table. A slot is occupied while its remaining count is nonzero.
  logic [fsjs_pkg::TAG_W-1:0]           slot_tag        [fsjs_pkg::SLOTS];
  logic [fsjs_pkg::UNITS_W-1:0]         remaining_units [fsjs_pkg::SLOTS];
  logic [fsjs_pkg::STAMP_W-1:0]         arrival_stamp   [fsjs_pkg::SLOTS];

  logic [fsjs_pkg::FILL_W-1:0]          fill_pointer;
  logic [fsjs_pkg::FILL_W-1:0]          active_jobs;
  logic [fsjs_pkg::SLOT_W-1:0]          current_slot;
  logic [fsjs_pkg::STAMP_W-1:0]         stamp_counter;

  // Latched command word.
  logic                                 act_q;
  logic [fsjs_pkg::TAG_W-1:0]           tag_q;
  logic [fsjs_pkg::UNITS_W-1:0]         burst_q;

  // Sequencer and scan registers.
  fsjs_pkg::state_t                     state, state_next;
  logic [fsjs_pkg::SLOT_W-1:0]          scan_idx;
  logic [fsjs_pkg::SLOT_W-1:0]          best_idx;
  logic [fsjs_pkg::STAMP_W-1:0]         best_key;
  logic                                 best_found;

  // Control decoded from the state.
  logic                                 take_cmd;
  logic                                 scan_en;
  logic                                 upd_en;
  logic                                 scan_last;

  // Single table read port.
  logic [fsjs_pkg::SLOT_W-1:0]          rd_addr;
  logic [fsjs_pkg::UNITS_W-1:0]         rd_rem;
  logic [fsjs_pkg::STAMP_W-1:0]         rd_stamp;
  logic [fsjs_pkg::TAG_W-1:0]           rd_tag;

  // Shared compare unit for the scan.
  logic [fsjs_pkg::STAMP_W-1:0]         cand_key;
  logic                                 cand_better;

  // Update logic results.
  logic                                 wr_en;
  logic                                 tag_we;
  logic [fsjs_pkg::SLOT_W-1:0]          wr_addr;
  logic [fsjs_pkg::UNITS_W-1:0]         wr_rem;
  logic [fsjs_pkg::STAMP_W-1:0]         wr_stamp;
  logic [fsjs_pkg::STAMP_W-1:0]         stamp_counter_next;
  logic [fsjs_pkg::FILL_W-1:0]          fill_pointer_next;
  logic [fsjs_pkg::FILL_W-1:0]          active_jobs_next;
  logic [fsjs_pkg::SLOT_W-1:0]          current_slot_next;
  logic                                 accepted_next;
  logic                                 dispatched_next;
  logic [fsjs_pkg::UNITS_W-1:0]         units_run_next;
  logic                                 job_done_next;
  logic [fsjs_pkg::SLOT_W-1:0]          slot_run_next;
  logic [fsjs_pkg::TAG_W-1:0]           tag_run_next;

  logic [fsjs_pkg::STAMP_W-1:0]         stamp_inc;
  logic [fsjs_pkg::QUANT_W-1:0]         quantum;
  logic [fsjs_pkg::FILL_W-1:0]          fill_base;
  logic                                 found;
  logic                                 finish;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      scheduling_mode <= fsjs_pkg::MODE_FCFS;
      rr_quantum      <= fsjs_pkg::QUANT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fsjs_pkg::REG_MODE:    scheduling_mode <= fsjs_pkg::mode_t'(cfg_data[1:0]);
        fsjs_pkg::REG_QUANTUM: rr_quantum      <= cfg_data[fsjs_pkg::QUANT_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      fsjs_pkg::S_IDLE: begin
        if (start) begin
          // Adds and FCFS need no walk over the table.
          if (action == fsjs_pkg::ACT_ADD || scheduling_mode == fsjs_pkg::MODE_FCFS) begin
            state_next = fsjs_pkg::S_UPDATE;
          end else begin
            state_next = fsjs_pkg::S_SCAN;
          end
        end
      end
      fsjs_pkg::S_SCAN: begin
        if (scan_last) begin
          state_next = fsjs_pkg::S_UPDATE;
        end
      end
      fsjs_pkg::S_UPDATE: state_next = fsjs_pkg::S_IDLE;
      default:            state_next = fsjs_pkg::S_IDLE;
    endcase
  end

  // State decode.
  always_comb begin
    busy     = 1'b1;
    take_cmd = 1'b0;
    scan_en  = 1'b0;
    upd_en   = 1'b0;
    case (state)
      fsjs_pkg::S_IDLE: begin
        busy     = 1'b0;
        take_cmd = start;
      end
      fsjs_pkg::S_SCAN:   scan_en = 1'b1;
      fsjs_pkg::S_UPDATE: upd_en  = 1'b1;
      default:            busy    = 1'b1;
    endcase
  end

  assign scan_last = (scan_idx == fsjs_pkg::SLOT_W'(fsjs_pkg::SLOTS - 1));

  // The table has one read address: the walk position while scanning,
  // the chosen slot during the update.
  assign rd_addr  = scan_en ? scan_idx : best_idx;
  assign rd_rem   = remaining_units[rd_addr];
  assign rd_stamp = arrival_stamp[rd_addr];
  assign rd_tag   = slot_tag[rd_addr];

  // Round robin ranks by stamp, the shortest job policies by remaining work.
  // Strict less-than keeps the lowest slot among equal keys.
  assign cand_key = (scheduling_mode == fsjs_pkg::MODE_RR) ? rd_stamp :
                    {{(fsjs_pkg::STAMP_W - fsjs_pkg::UNITS_W){1'b0}}, rd_rem};
  assign cand_better = (rd_rem != '0) && (!best_found || cand_key < best_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsjs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command latch and scan registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (take_cmd) begin
      best_found <= 1'b0;
    end else if (scan_en && cand_better) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_cmd) begin
      act_q    <= action;
      tag_q    <= job_tag;
      burst_q  <= burst_units;
      scan_idx <= '0;
      // FCFS looks only at the slot under the walk pointer.
      best_idx <= current_slot;
    end else if (scan_en) begin
      scan_idx <= fsjs_pkg::slot_next(scan_idx);
      if (cand_better) begin
        best_idx <= scan_idx;
        best_key <= cand_key;
      end
    end
  end

  // Update logic: one decision per command, applied in the update cycle.
  assign stamp_inc = stamp_counter + fsjs_pkg::STAMP_W'(1);
  assign quantum   = (rr_quantum == '0) ? fsjs_pkg::QUANT_W'(1) : rr_quantum;
  // Once the table has drained, filling restarts at slot 0.
  assign fill_base = (active_jobs == '0) ? '0 : fill_pointer;
  assign found     = (scheduling_mode == fsjs_pkg::MODE_FCFS) ? (rd_rem != '0) : best_found;

  always_comb begin
    wr_en              = 1'b0;
    tag_we             = 1'b0;
    wr_addr            = best_idx;
    wr_rem             = rd_rem;
    wr_stamp           = rd_stamp;
    stamp_counter_next = stamp_counter;
    fill_pointer_next  = fill_pointer;
    active_jobs_next   = active_jobs;
    current_slot_next  = current_slot;
    accepted_next      = 1'b0;
    dispatched_next    = 1'b0;
    units_run_next     = '0;
    job_done_next      = 1'b0;
    slot_run_next      = '0;
    tag_run_next       = '0;
    finish             = 1'b0;

    if (act_q == fsjs_pkg::ACT_ADD) begin
      fill_pointer_next = fill_base;
      if (fill_base < fsjs_pkg::FILL_W'(fsjs_pkg::SLOTS) && burst_q != '0) begin
        wr_en              = 1'b1;
        tag_we             = 1'b1;
        wr_addr            = fill_base[fsjs_pkg::SLOT_W-1:0];
        wr_rem             = burst_q;
        wr_stamp           = stamp_inc;
        stamp_counter_next = stamp_inc;
        fill_pointer_next  = fill_base + fsjs_pkg::FILL_W'(1);
        active_jobs_next   = active_jobs + fsjs_pkg::FILL_W'(1);
        accepted_next      = 1'b1;
      end
    end else if (!found) begin
      // FCFS keeps walking past an empty slot while jobs remain.
      if (scheduling_mode == fsjs_pkg::MODE_FCFS && active_jobs != '0) begin
        current_slot_next = fsjs_pkg::slot_next(best_idx);
      end else begin
        current_slot_next = '0;
      end
    end else begin
      wr_en             = 1'b1;
      dispatched_next   = 1'b1;
      slot_run_next     = best_idx;
      tag_run_next      = rd_tag;
      current_slot_next = best_idx;
      case (scheduling_mode)
        fsjs_pkg::MODE_FCFS: begin
          units_run_next    = rd_rem;
          finish            = 1'b1;
          current_slot_next = fsjs_pkg::slot_next(best_idx);
        end
        fsjs_pkg::MODE_SJF: begin
          units_run_next = rd_rem;
          finish         = 1'b1;
        end
        fsjs_pkg::MODE_PSJF: begin
          units_run_next = fsjs_pkg::UNITS_W'(1);
          wr_rem         = rd_rem - fsjs_pkg::UNITS_W'(1);
          finish         = (rd_rem == fsjs_pkg::UNITS_W'(1));
        end
        fsjs_pkg::MODE_RR: begin
          if (rd_rem <= fsjs_pkg::UNITS_W'(quantum)) begin
            units_run_next = rd_rem;
            finish         = 1'b1;
          end else begin
            // The job goes to the back of the line with a fresh stamp.
            units_run_next     = fsjs_pkg::UNITS_W'(quantum);
            wr_rem             = rd_rem - fsjs_pkg::UNITS_W'(quantum);
            wr_stamp           = stamp_inc;
            stamp_counter_next = stamp_inc;
          end
        end
        default: ;
      endcase
      if (finish) begin
        wr_rem        = '0;
        wr_stamp      = '0;
        job_done_next = 1'b1;
        if (active_jobs != '0) begin
          active_jobs_next = active_jobs - fsjs_pkg::FILL_W'(1);
        end
      end
    end
  end

  // Table write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fsjs_pkg::SLOTS; i++) begin
        remaining_units[i] <= '0;
        arrival_stamp[i]   <= '0;
      end
    end else if (upd_en && wr_en) begin
      remaining_units[wr_addr] <= wr_rem;
      arrival_stamp[wr_addr]   <= wr_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && tag_we) begin
      slot_tag[wr_addr] <= tag_q;
    end
  end

  // Scheduler bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_pointer  <= '0;
      active_jobs   <= '0;
      current_slot  <= '0;
      stamp_counter <= '0;
    end else if (upd_en) begin
      fill_pointer  <= fill_pointer_next;
      active_jobs   <= active_jobs_next;
      current_slot  <= current_slot_next;
      stamp_counter <= stamp_counter_next;
    end
  end

  // Result register: written once per command, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= upd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      accepted   <= accepted_next;
      dispatched <= dispatched_next;
      slot_run   <= 2'(slot_run_next);
      tag_run    <= tag_run_next;
      units_run  <= units_run_next;
      job_done   <= job_done_next;
    end
  end

endmodule

FILE: rtl/fsjs_checker.sv
// Port-level checker for the four-slot job scheduler, bound to the top level.
// Depends on fsjs_pkg for field widths.
module fsjs_port_asserts (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic                            accepted,
  input logic                            dispatched,
  input logic [fsjs_pkg::UNITS_W-1:0]    units_run,
  input logic                            job_done
);

  // A taken command always makes the block busy in the next cycle.
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken but block not busy");

  // Busy only rises after a command was offered.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // The result word appears as the command finishes, never while busy.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result shown while busy");

  // An add word never dispatches, and a finished job was dispatched.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> (!(accepted && dispatched) && (!job_done || dispatched)))
    else $error("inconsistent result word");

  // A dispatch grants work.
  a_units: assert property (@(posedge clk) disable iff (rst)
    (done && dispatched) |-> (units_run != '0))
    else $error("dispatch granted no units");

endmodule

bind four_slot_job_scheduler fsjs_port_asserts u_fsjs_port_asserts (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .accepted   (accepted),
  .dispatched (dispatched),
  .units_run  (units_run),
  .job_done   (job_done)
);

FILE: bench/fsjs_checker.sv
// Scoreboard for the four-slot job scheduler: tracks the job table on its own,
// predicts one result word per command word and compares the result channel.
// Depends on fsjs_pkg.
module fsjs_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            action,
  input  logic [fsjs_pkg::TAG_W-1:0]      job_tag,
  input  logic [fsjs_pkg::UNITS_W-1:0]    burst_units,
  input  logic                            done,
  input  logic                            accepted,
  input  logic                            dispatched,
  input  logic [1:0]                      slot_run,
  input  logic [fsjs_pkg::TAG_W-1:0]      tag_run,
  input  logic [fsjs_pkg::UNITS_W-1:0]    units_run,
  input  logic                            job_done,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [fsjs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsjs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_count,
  output int                              checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                         accepted;
    logic                         dispatched;
    logic [fsjs_pkg::SLOT_W-1:0]  slot;
    logic [fsjs_pkg::TAG_W-1:0]   tag;
    logic [fsjs_pkg::UNITS_W-1:0] units;
    logic                         finished;
  } sched_word_t;

  fsjs_pkg::mode_t               policy;
  logic [fsjs_pkg::QUANT_W-1:0]  quantum;
  logic [fsjs_pkg::TAG_W-1:0]    tag_of   [fsjs_pkg::SLOTS];
  logic [fsjs_pkg::UNITS_W-1:0]  left_of  [fsjs_pkg::SLOTS];
  logic [fsjs_pkg::STAMP_W-1:0]  stamp_of [fsjs_pkg::SLOTS];
  logic [fsjs_pkg::FILL_W-1:0]   fill;
  logic [fsjs_pkg::FILL_W-1:0]   live;
  logic [fsjs_pkg::SLOT_W-1:0]   walk;
  logic [fsjs_pkg::STAMP_W-1:0]  stamp_now;
  sched_word_t                   sched_q[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
  end

  function automatic void clear_table();
    policy    = fsjs_pkg::MODE_FCFS;
    quantum   = fsjs_pkg::QUANT_RESET;
    fill      = '0;
    live      = '0;
    walk      = '0;
    stamp_now = '0;
    for (int i = 0; i < fsjs_pkg::SLOTS; i++) begin
      tag_of[i]   = '0;
      left_of[i]  = '0;
      stamp_of[i] = '0;
    end
  endfunction

  function automatic void retire(int s);
    left_of[s]  = '0;
    stamp_of[s] = '0;
    if (live != 0) live = live - 1'b1;
  endfunction

  // Applies one command word to the table and returns the word it should produce.
  function automatic sched_word_t schedule(logic act, logic [fsjs_pkg::TAG_W-1:0] t,
                                           logic [fsjs_pkg::UNITS_W-1:0] b);
    sched_word_t                  r;
    int                           pick;
    logic [fsjs_pkg::UNITS_W-1:0] rem;
    logic [fsjs_pkg::UNITS_W-1:0] q;
    r    = '0;
    pick = -1;
    if (act == fsjs_pkg::ACT_ADD) begin
      // Slots are handed out again only after the table has fully emptied.
      if (live == 0) fill = '0;
      if (fill < fsjs_pkg::SLOTS && b != 0) begin
        stamp_now = stamp_now + 1;
        tag_of[fill[fsjs_pkg::SLOT_W-1:0]]   = t;
        left_of[fill[fsjs_pkg::SLOT_W-1:0]]  = b;
        stamp_of[fill[fsjs_pkg::SLOT_W-1:0]] = stamp_now;
        fill = fill + 1'b1;
        live = live + 1'b1;
        r.accepted = 1'b1;
      end
    end else if (policy == fsjs_pkg::MODE_FCFS) begin
      if (left_of[walk] == 0) begin
        walk = (live != 0) ?
               fsjs_pkg::SLOT_W'((int'(walk) + 1) % fsjs_pkg::SLOTS) : '0;
      end else begin
        pick       = walk;
        r.units    = left_of[walk];
        r.finished = 1'b1;
        retire(pick);
        walk = fsjs_pkg::SLOT_W'((int'(walk) + 1) % fsjs_pkg::SLOTS);
      end
    end else begin
      // Strict compares keep the lowest slot on ties.
      for (int i = 0; i < fsjs_pkg::SLOTS; i++) begin
        if (left_of[i] != 0) begin
          if (pick < 0) begin
            pick = i;
          end else if (policy == fsjs_pkg::MODE_RR ? stamp_of[i] < stamp_of[pick]
                                                   : left_of[i] < left_of[pick]) begin
            pick = i;
          end
        end
      end
      if (pick < 0) begin
        walk = '0;
      end else begin
        walk = fsjs_pkg::SLOT_W'(pick);
        rem  = left_of[pick];
        case (policy)
          fsjs_pkg::MODE_SJF: begin
            r.units    = rem;
            r.finished = 1'b1;
            retire(pick);
          end
          fsjs_pkg::MODE_PSJF: begin
            r.units       = fsjs_pkg::UNITS_W'(1);
            left_of[pick] = rem - 1'b1;
            if (rem == 1) begin
              r.finished = 1'b1;
              retire(pick);
            end
          end
          default: begin
            q = (quantum == 0) ? fsjs_pkg::UNITS_W'(1) : fsjs_pkg::UNITS_W'(quantum);
            if (rem <= q) begin
              r.units    = rem;
              r.finished = 1'b1;
              retire(pick);
            end else begin
              r.units        = q;
              left_of[pick]  = rem - q;
              stamp_now      = stamp_now + 1;
              stamp_of[pick] = stamp_now;
            end
          end
        endcase
      end
    end
    if (pick >= 0) begin
      r.dispatched = 1'b1;
      r.slot       = fsjs_pkg::SLOT_W'(pick);
      r.tag        = tag_of[pick];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    sched_word_t want;
    if (rst) begin
      clear_table();
      sched_q.delete();
    end else begin
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          fsjs_pkg::REG_MODE:    policy  = fsjs_pkg::mode_t'(cfg_data[1:0]);
          fsjs_pkg::REG_QUANTUM: quantum = cfg_data[fsjs_pkg::QUANT_W-1:0];
          default: ;
        endcase
      end
      if (done === 1'b1) begin
        if (sched_q.size() == 0) begin
          $error("result word with no command outstanding");
          fail_count++;
        end else begin
          want = sched_q.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(accepted));
          check_field("dispatched", 32'(want.dispatched), 32'(dispatched));
          check_field("slot_run", 32'(want.slot), 32'(slot_run));
          check_field("tag_run", 32'(want.tag), 32'(tag_run));
          check_field("units_run", 32'(want.units), 32'(units_run));
          check_field("job_done", 32'(want.finished), 32'(job_done));
          checked_count++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        sched_q.push_back(schedule(action, job_tag, burst_units));
      end
    end
    pending_count = sched_q.size();
  end

endmodule

FILE: bench/tb_top.sv
// Top of the four-slot job scheduler bench: clock, reset, command and register
// stimulus, and the verdict. Depends on fsjs_pkg, four_slot_job_scheduler and
// fsjs_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            start       = 1'b0;
  logic                            action      = fsjs_pkg::ACT_ADD;
  logic [fsjs_pkg::TAG_W-1:0]      job_tag     = '0;
  logic [fsjs_pkg::UNITS_W-1:0]    burst_units = '0;
  logic                            cfg_valid   = 1'b0;
  logic [fsjs_pkg::CFG_IDX_W-1:0]  cfg_index   = fsjs_pkg::REG_MODE;
  logic [fsjs_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

  logic                            busy;
  logic                            done;
  logic                            accepted;
  logic                            dispatched;
  logic [1:0]                      slot_run;
  logic [fsjs_pkg::TAG_W-1:0]      tag_run;
  logic [fsjs_pkg::UNITS_W-1:0]    units_run;
  logic                            job_done;
  logic                            cfg_ready;

  int fails;
  int pending;
  int checked;
  int words_sent    = 0;
  int directed_sent = 0;
  // Share of cycles, in percent, in which the sender holds start low.
  int idle_pct      = 0;

  // The scheduling policies in the order each phase visits them.
  fsjs_pkg::mode_t policy_order[4] = '{fsjs_pkg::MODE_FCFS, fsjs_pkg::MODE_SJF,
                                       fsjs_pkg::MODE_PSJF, fsjs_pkg::MODE_RR};

  four_slot_job_scheduler dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .job_tag     (job_tag),
    .burst_units (burst_units),
    .done        (done),
    .accepted    (accepted),
    .dispatched  (dispatched),
    .slot_run    (slot_run),
    .tag_run     (tag_run),
    .units_run   (units_run),
    .job_done    (job_done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // The scoreboard sits beside the block and sees exactly the same pins.
  fsjs_checker sched_chk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .job_tag       (job_tag),
    .burst_units   (burst_units),
    .done          (done),
    .accepted      (accepted),
    .dispatched    (dispatched),
    .slot_run      (slot_run),
    .tag_run       (tag_run),
    .units_run     (units_run),
    .job_done      (job_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fails),
    .pending_count (pending),
    .checked_count (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog. A run that has not finished by the timeout is reported as
  // failed. In the slowest legal run every dispatch would walk the table,
  // and the sender is quiet 79 percent of the time for a third of the words.
  initial begin
    #3ms;
    $display("tb_top failed");
    $finish;
  end

  // Presents one command word from the falling edge until the block takes
  // it. Each cycle the sender may instead stay quiet with start low, with a
  // chance of idle_pct percent. Start stays high after the word is taken so
  // that the next word can go back to back.
  task automatic send_word(input logic act, input logic [fsjs_pkg::TAG_W-1:0] t,
                           input logic [fsjs_pkg::UNITS_W-1:0] b);
    logic taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end else begin
        start       <= 1'b1;
        action      <= act;
        job_tag     <= t;
        burst_units <= b;
        @(posedge clk);
        taken = (busy === 1'b0);
      end
    end
    words_sent++;
  endtask

  // Stops sending and waits until every outstanding result word has come back.
  // Register writes are only made from this quiet state.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [fsjs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fsjs_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random command word. Adds and dispatches are mixed so the table keeps
  // filling up and emptying; bursts are mostly short so that preemptive SJF
  // and small round robin quanta still finish jobs often. The unused fields
  // of a dispatch word carry random values as well.
  task automatic send_random(input int add_pct);
    logic                         act;
    logic [fsjs_pkg::UNITS_W-1:0] b;
    int                           r;
    act = ($urandom_range(99) < add_pct) ? fsjs_pkg::ACT_ADD : fsjs_pkg::ACT_DISPATCH;
    r   = $urandom_range(99);
    if (r < 5)       b = '0;
    else if (r < 10) b = '1;
    else if (r < 65) b = fsjs_pkg::UNITS_W'($urandom_range(1, 6));
    else             b = fsjs_pkg::UNITS_W'($urandom_range(1, 31));
    send_word(act, fsjs_pkg::TAG_W'($urandom_range(3)), b);
  endtask

  initial begin
    logic [fsjs_pkg::QUANT_W-1:0] quant;
    int                           add_pct;
    int                           qsel;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---------------- Directed part, back to back words ----------------
    // Reset state is FCFS with a quantum of three.
    send_word(fsjs_pkg::ACT_DISPATCH, 2'd0, 5'd0);   // dispatch on an empty table
    send_word(fsjs_pkg::ACT_ADD, 2'd0, 5'd0);        // zero burst is refused
    send_word(fsjs_pkg::ACT_ADD, 2'd0, 5'd1);        // shortest possible job
    send_word(fsjs_pkg::ACT_ADD, 2'd1, 5'd31);       // longest possible job
    send_word(fsjs_pkg::ACT_ADD, 2'd2, 5'd10);
    send_word(fsjs_pkg::ACT_ADD, 2'd3, 5'd21);
    send_word(fsjs_pkg::ACT_ADD, 2'd2, 5'd31);       // table full, refused
    repeat (4) send_word(fsjs_pkg::ACT_DISPATCH, 2'd3, 5'd31);
    send_word(fsjs_pkg::ACT_DISPATCH, 2'd1, 5'd17);  // dispatch on the emptied table

    // Shortest job first; two equal lengths must resolve to the lower slot.
    drain_results();
    write_reg(fsjs_pkg::REG_MODE, fsjs_pkg::CFG_DATA_W'(fsjs_pkg::MODE_SJF));
    send_word(fsjs_pkg::ACT_ADD, 2'd3, 5'd7);
    send_word(fsjs_pkg::ACT_ADD, 2'd2, 5'd2);
    send_word(fsjs_pkg::ACT_ADD, 2'd1, 5'd2);
    repeat (3) send_word(fsjs_pkg::ACT_DISPATCH, 2'd0, 5'd0);

    // Preemptive SJF runs one unit at a time.
    drain_results();
    write_reg(fsjs_pkg::REG_MODE, fsjs_pkg::CFG_DATA_W'(fsjs_pkg::MODE_PSJF));
    send_word(fsjs_pkg::ACT_ADD, 2'd0, 5'd2);
    send_word(fsjs_pkg::ACT_ADD, 2'd1, 5'd1);
    repeat (3) send_word(fsjs_pkg::ACT_DISPATCH, 2'd0, 5'd0);

    // Round robin with the reset quantum: both jobs get restamped once,
    // and one job is left in slot one for the FCFS walk below.
    drain_results();
    write_reg(fsjs_pkg::REG_MODE, fsjs_pkg::CFG_DATA_W'(fsjs_pkg::MODE_RR));
    send_word(fsjs_pkg::ACT_ADD, 2'd1, 5'd4);
    send_word(fsjs_pkg::ACT_ADD, 2'd2, 5'd9);
    repeat (3) send_word(fsjs_pkg::ACT_DISPATCH, 2'd0, 5'd0);

    // FCFS walking onto an empty slot while a job is still waiting further on.
    drain_results();
    write_reg(fsjs_pkg::REG_MODE, fsjs_pkg::CFG_DATA_W'(fsjs_pkg::MODE_FCFS));
    repeat (2) send_word(fsjs_pkg::ACT_DISPATCH, 2'd0, 5'd0);
    directed_sent = words_sent;

    // ---------------- Random part ----------------
    // Three phases: a sender that rarely idles, one that idles most of the
    // time, then none at all. Each phase visits every policy twice, and the
    // block is drained before every register change.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 6 : (phase == 1) ? 79 : 0;
      for (int seg = 0; seg < 8; seg++) begin
        drain_results();
        // Upper data bits of the mode write are ignored by the block.
        write_reg(fsjs_pkg::REG_MODE,
                  {2'($urandom_range(3)), 2'(policy_order[seg % 4])});
        // Round robin segments step through quanta 1, 15, 0 and a random one.
        qsel = ((phase * 8 + seg) / 4) % 4;
        case (qsel)
          0:       quant = 4'd1;
          1:       quant = 4'd15;
          2:       quant = 4'd0;
          default: quant = fsjs_pkg::QUANT_W'($urandom_range(1, 15));
        endcase
        write_reg(fsjs_pkg::REG_QUANTUM, fsjs_pkg::CFG_DATA_W'(quant));
        add_pct = $urandom_range(35, 60);
        repeat (58) send_random(add_pct);
      end
    end

    // Let the last results come back, then give the block a few more cycles
    // to show any stray result word.
    drain_results();
    repeat (8) @(posedge clk);

    $display("Ran %0d command words (%0d directed) and checked %0d result words,",
             words_sent, directed_sent, checked);
    $display("covering all four policies, quanta 0, 1 and 15, and three sender idle rates.");
    if (fails == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/fsjs_pkg.sv
rtl/four_slot_job_scheduler.sv
rtl/fsjs_checker.sv
bench/fsjs_checker.sv
bench/tb_top.sv
